FILE: sv/v3alu_pkg.sv
// Package for the three-component vector unit: word and pipeline widths,
// opcode and status codes, item types and the saturation helper.
// No dependencies.
`default_nettype none

package v3alu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int OW  = WORD_BITS + 1;
  localparam int PW  = 2 * OW;
  localparam int SW  = PW + 2;
  localparam int RB  = WORD_BITS + 1;
  localparam int RW  = 2 * RB;
  localparam int RMW = RB + 2;
  localparam int DW  = 2 * WORD_BITS;
  localparam int NW  = 3 * WORD_BITS;
  localparam int QB  = WORD_BITS + 2;
  localparam int DVW = 2 * WORD_BITS;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_SCALE   = 4'd2,
    OP_DOT     = 4'd3,
    OP_CROSS   = 4'd4,
    OP_LENSQ   = 4'd5,
    OP_LEN     = 4'd6,
    OP_DIST    = 4'd7,
    OP_UNIT    = 4'd8,
    OP_PROJECT = 4'd9
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [3:0]                  opcode;
    logic signed [WORD_BITS-1:0] ax;
    logic signed [WORD_BITS-1:0] ay;
    logic signed [WORD_BITS-1:0] az;
    logic signed [WORD_BITS-1:0] bx;
    logic signed [WORD_BITS-1:0] by;
    logic signed [WORD_BITS-1:0] bz;
    logic signed [WORD_BITS-1:0] scale_factor;
  } vec_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] rx;
    logic signed [WORD_BITS-1:0] ry;
    logic signed [WORD_BITS-1:0] rz;
    logic signed [WORD_BITS-1:0] rscalar;
    logic [1:0]                  status;
  } vec_out_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 sat;
  } sat_t;

  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO =
    {{(SW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  function automatic sat_t sat_word(input logic signed [SW-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.word = SAT_HI[WORD_BITS-1:0];
      r.sat  = 1'b1;
    end else if (v < SAT_LO) begin
      r.word = SAT_LO[WORD_BITS-1:0];
      r.sat  = 1'b1;
    end else begin
      r.word = v[WORD_BITS-1:0];
      r.sat  = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/vector3_alu.sv
// Vector unit on two Q16.16 3-vectors and a scalar, fully pipelined.
// Depends on v3alu_pkg (widths, codes, item types, saturation).
// Takes one item on every cycle in which start is high; busy never rises and the
// result strobe done_o cannot be held off. Each item's result shows on result_o
// for one cycle with done_o, once the item has passed the 33-stage square root
// pipeline and the 34-stage restoring divider that follows it. All opcodes take
// the same path, so results leave in the order the items came in, one per cycle
// at full rate.
`default_nettype none

module vector3_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  v3alu_pkg::vec_in_t  item_i,
  output logic                done_o,
  output v3alu_pkg::vec_out_t result_o
);
  import v3alu_pkg::*;

  localparam int LAT = RB + QB + 9;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [OW-1:0]        opd_t;
  typedef logic signed [PW-1:0]        prod_t;
  typedef logic signed [SW-1:0]        sum_t;

  typedef struct packed {
    logic [3:0]              op;
    vec_out_t                early;
    logic [2:0]              neg;
    logic [2:0][NW-1:0]      num;
    logic [DVW-1:0]          dvp;
    logic                    zp;
  } cargo_t;

  typedef struct packed {
    logic [3:0] op;
    vec_out_t   early;
    logic [2:0] neg;
    logic       zero;
  } dcarry_t;

  // stage 1
  vec_in_t in_q;
  logic    v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= item_i;
    end
  end

  // stage 2: operand select
  word_t a1 [3];
  word_t b1 [3];
  opd_t  ae [3];
  opd_t  be [3];
  opd_t  e1 [3];
  opd_t  se;
  opd_t  ma_d [6];
  opd_t  mb_d [6];
  opd_t  as_d [3];

  always_comb begin
    a1[0] = in_q.ax;
    a1[1] = in_q.ay;
    a1[2] = in_q.az;
    b1[0] = in_q.bx;
    b1[1] = in_q.by;
    b1[2] = in_q.bz;
    se    = OW'(in_q.scale_factor);
    for (int i = 0; i < 3; i++) begin
      ae[i]     = OW'(a1[i]);
      be[i]     = OW'(b1[i]);
      e1[i]     = ae[i] - be[i];
      ma_d[i]   = ae[i];
      mb_d[i]   = be[i];
      ma_d[i+3] = be[i];
      mb_d[i+3] = be[i];
      as_d[i]   = (in_q.opcode == OP_SUB) ? e1[i] : ae[i] + be[i];
    end
    case (in_q.opcode)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) mb_d[i] = se;
      end
      OP_CROSS: begin
        ma_d[0] = ae[1]; mb_d[0] = be[2]; ma_d[3] = ae[2]; mb_d[3] = be[1];
        ma_d[1] = ae[2]; mb_d[1] = be[0]; ma_d[4] = ae[0]; mb_d[4] = be[2];
        ma_d[2] = ae[0]; mb_d[2] = be[1]; ma_d[5] = ae[1]; mb_d[5] = be[0];
      end
      OP_LENSQ, OP_LEN, OP_UNIT: begin
        for (int i = 0; i < 3; i++) mb_d[i] = ae[i];
      end
      OP_DIST: begin
        for (int i = 0; i < 3; i++) begin
          ma_d[i] = e1[i];
          mb_d[i] = e1[i];
        end
      end
      default: ;
    endcase
  end

  opd_t       ma_q [6];
  opd_t       mb_q [6];
  opd_t       as2_q [3];
  word_t      a2_q [3];
  word_t      b2_q [3];
  logic [3:0] op2_q;
  logic       v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    as2_q <= as_d;
    a2_q  <= a1;
    b2_q  <= b1;
    op2_q <= in_q.opcode;
  end

  // stage 3: products
  prod_t      p_q [6];
  opd_t       as3_q [3];
  word_t      a3_q [3];
  word_t      b3_q [3];
  logic [3:0] op3_q;
  logic       v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) p_q[k] <= ma_q[k] * mb_q[k];
    as3_q <= as2_q;
    a3_q  <= a2_q;
    b3_q  <= b2_q;
    op3_q <= op2_q;
  end

  // stage 4: sums
  sum_t vs_d [3];
  sum_t ssum_d;
  sum_t nsum_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (op3_q)
        OP_SCALE: vs_d[i] = SW'(p_q[i]);
        OP_CROSS: vs_d[i] = SW'(p_q[i]) - SW'(p_q[i+3]);
        default:  vs_d[i] = SW'(as3_q[i]);
      endcase
    end
    ssum_d = SW'(p_q[0]) + SW'(p_q[1]) + SW'(p_q[2]);
    nsum_d = SW'(p_q[3]) + SW'(p_q[4]) + SW'(p_q[5]);
  end

  sum_t       vs4_q [3];
  sum_t       ssum4_q;
  sum_t       nsum4_q;
  word_t      a4_q [3];
  word_t      b4_q [3];
  logic [3:0] op4_q;
  logic       v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vs4_q   <= vs_d;
    ssum4_q <= ssum_d;
    nsum4_q <= nsum_d;
    a4_q    <= a3_q;
    b4_q    <= b3_q;
    op4_q   <= op3_q;
  end

  // stage 5: direct results, magnitudes for the divider path
  sat_t                 sv [3];
  sat_t                 ss;
  vec_out_t             early5_d;
  sum_t                 dfull;
  logic [WORD_BITS-1:0] bm_d [3];
  logic [WORD_BITS-1:0] am_d [3];
  logic [2:0]           bn_d;
  logic [2:0]           an_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op4_q inside {OP_SCALE, OP_CROSS}) begin
        sv[i] = sat_word(vs4_q[i] >>> FRAC_BITS);
      end else begin
        sv[i] = sat_word(vs4_q[i]);
      end
      bn_d[i] = b4_q[i][WORD_BITS-1];
      an_d[i] = a4_q[i][WORD_BITS-1];
      bm_d[i] = bn_d[i] ? WORD_BITS'(~b4_q[i] + 1'b1) : b4_q[i];
      am_d[i] = an_d[i] ? WORD_BITS'(~a4_q[i] + 1'b1) : a4_q[i];
    end
    ss = sat_word(ssum4_q >>> FRAC_BITS);
    early5_d = '0;
    case (op4_q)
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        early5_d.rx     = sv[0].word;
        early5_d.ry     = sv[1].word;
        early5_d.rz     = sv[2].word;
        early5_d.status = (sv[0].sat || sv[1].sat || sv[2].sat) ? ST_SAT : ST_OK;
      end
      OP_DOT, OP_LENSQ: begin
        early5_d.rscalar = ss.word;
        early5_d.status  = ss.sat ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
    dfull = ssum4_q[SW-1] ? -ssum4_q : ssum4_q;
  end

  vec_out_t             early5_q;
  logic [DW-1:0]        dabs5_q;
  logic                 dneg5_q;
  logic [WORD_BITS-1:0] bm5_q [3];
  logic [WORD_BITS-1:0] am5_q [3];
  logic [2:0]           bn5_q;
  logic [2:0]           an5_q;
  logic [RW-1:0]        rad5_q;
  sum_t                 nsum5_q;
  logic [3:0]           op5_q;
  logic                 v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    early5_q <= early5_d;
    dabs5_q  <= dfull[DW-1:0];
    dneg5_q  <= ssum4_q[SW-1];
    bm5_q    <= bm_d;
    am5_q    <= am_d;
    bn5_q    <= bn_d;
    an5_q    <= an_d;
    rad5_q   <= ssum4_q[RW-1:0];
    nsum5_q  <= nsum4_q;
    op5_q    <= op4_q;
  end

  // stage 6: projection numerator partial products
  logic [DW-1:0]        plo6_q [3];
  logic [DW-1:0]        phi6_q [3];
  vec_out_t             early6_q;
  logic                 dneg6_q;
  logic [WORD_BITS-1:0] am6_q [3];
  logic [2:0]           bn6_q;
  logic [2:0]           an6_q;
  logic [RW-1:0]        rad6_q;
  sum_t                 nsum6_q;
  logic [3:0]           op6_q;
  logic                 v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      plo6_q[i] <= DW'(bm5_q[i]) * DW'(dabs5_q[WORD_BITS-1:0]);
      phi6_q[i] <= DW'(bm5_q[i]) * DW'(dabs5_q[DW-1:WORD_BITS]);
    end
    early6_q <= early5_q;
    dneg6_q  <= dneg5_q;
    am6_q    <= am5_q;
    bn6_q    <= bn5_q;
    an6_q    <= an5_q;
    rad6_q   <= rad5_q;
    nsum6_q  <= nsum5_q;
    op6_q    <= op5_q;
  end

  // stage 7: dividend select, square root entry
  cargo_t cargo_d;

  always_comb begin
    cargo_d.op    = op6_q;
    cargo_d.early = early6_q;
    cargo_d.dvp   = nsum6_q[DVW-1:0];
    cargo_d.zp    = (nsum6_q == '0);
    for (int i = 0; i < 3; i++) begin
      if (op6_q == OP_UNIT) begin
        cargo_d.num[i] = NW'(am6_q[i]) << FRAC_BITS;
        cargo_d.neg[i] = an6_q[i];
      end else begin
        cargo_d.num[i] = NW'(plo6_q[i]) + (NW'(phi6_q[i]) << WORD_BITS);
        cargo_d.neg[i] = bn6_q[i] ^ dneg6_q;
      end
    end
  end

  cargo_t         sq_c_q    [RB+1];
  logic [RW-1:0]  sq_rad_q  [RB+1];
  logic [RMW-1:0] sq_rem_q  [RB+1];
  logic [RB-1:0]  sq_root_q [RB+1];
  logic           sq_v_q    [RB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_c_q[0]    <= cargo_d;
    sq_rad_q[0]  <= rad6_q;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [RMW+1:0] r;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           ge;

    assign r     = {sq_rem_q[k], sq_rad_q[k][RW-1 -: 2]};
    assign trial = {{(RMW-RB){1'b0}}, sq_root_q[k], 2'b01};
    assign ge    = (r >= trial);
    assign diff  = r - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_c_q[k+1]    <= sq_c_q[k];
      sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
      sq_rem_q[k+1]  <= ge ? diff[RMW-1:0] : r[RMW-1:0];
      sq_root_q[k+1] <= {sq_root_q[k][RB-2:0], ge};
    end
  end

  // divider entry
  dcarry_t                 dent_d;
  logic [DVW-1:0]          den_d;
  logic [2:0][DVW-1:0]     rem0_d;
  logic [2:0][QB-1:0]      nq0_d;
  sat_t                    rs;

  always_comb begin
    dent_d.op    = sq_c_q[RB].op;
    dent_d.early = sq_c_q[RB].early;
    dent_d.neg   = sq_c_q[RB].neg;
    rs = sat_word(SW'(sq_root_q[RB]));
    if (sq_c_q[RB].op inside {OP_LEN, OP_DIST}) begin
      dent_d.early.rscalar = rs.word;
      dent_d.early.status  = rs.sat ? ST_SAT : ST_OK;
    end
    if (sq_c_q[RB].op == OP_UNIT) begin
      den_d       = DVW'(sq_root_q[RB]);
      dent_d.zero = (sq_root_q[RB] == '0);
    end else begin
      den_d       = sq_c_q[RB].dvp;
      dent_d.zero = sq_c_q[RB].zp;
    end
    for (int i = 0; i < 3; i++) begin
      rem0_d[i] = DVW'(sq_c_q[RB].num[i] >> QB);
      nq0_d[i]  = sq_c_q[RB].num[i][QB-1:0];
    end
  end

  dcarry_t             div_c_q   [QB+1];
  logic [DVW-1:0]      div_den_q [QB+1];
  logic [2:0][DVW-1:0] div_rem_q [QB+1];
  logic [2:0][QB-1:0]  div_nq_q  [QB+1];
  logic                div_v_q   [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else begin
      div_v_q[0] <= sq_v_q[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    div_c_q[0]   <= dent_d;
    div_den_q[0] <= den_d;
    div_rem_q[0] <= rem0_d;
    div_nq_q[0]  <= nq0_d;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [2:0][DVW-1:0] rem_n;
    logic [2:0][QB-1:0]  nq_n;

    always_comb begin
      logic [DVW:0] r;
      logic [DVW:0] diff;
      logic         ge;
      for (int i = 0; i < 3; i++) begin
        r        = {div_rem_q[k][i], div_nq_q[k][i][QB-1]};
        ge       = (r >= {1'b0, div_den_q[k]});
        diff     = r - {1'b0, div_den_q[k]};
        rem_n[i] = ge ? diff[DVW-1:0] : r[DVW-1:0];
        nq_n[i]  = {div_nq_q[k][i][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k+1] <= 1'b0;
      end else begin
        div_v_q[k+1] <= div_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      div_c_q[k+1]   <= div_c_q[k];
      div_den_q[k+1] <= div_den_q[k];
      div_rem_q[k+1] <= rem_n;
      div_nq_q[k+1]  <= nq_n;
    end
  end

  // output stage
  vec_out_t res_d;
  sat_t     qv [3];

  always_comb begin
    logic [QB:0] qa;
    sum_t        qs;
    for (int i = 0; i < 3; i++) begin
      qa = {1'b0, div_nq_q[QB][i]} +
           (QB+1)'(div_c_q[QB].neg[i] && (div_rem_q[QB][i] != '0));
      qs = div_c_q[QB].neg[i] ? -SW'(qa) : SW'(qa);
      qv[i] = sat_word(qs);
    end
    res_d = div_c_q[QB].early;
    if (div_c_q[QB].op inside {OP_UNIT, OP_PROJECT}) begin
      res_d = '0;
      if (div_c_q[QB].zero) begin
        res_d.status = ST_ZERO;
      end else begin
        res_d.rx     = qv[0].word;
        res_d.ry     = qv[1].word;
        res_d.rz     = qv[2].word;
        res_d.status = (qv[0].sat || qv[1].sat || qv[2].sat) ? ST_SAT : ST_OK;
      end
    end
  end

  logic     done_q;
  vec_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy     = 1'b0;
  assign done_o   = done_q;
  assign result_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o)
    else $error("item did not complete at the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result strobe without a matching item");

  a_zero_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_ZERO) |->
      (result_o.rx == '0 && result_o.ry == '0 && result_o.rz == '0 &&
       result_o.rscalar == '0))
    else $error("zero-divisor result carries data");

  a_scalar_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.rscalar != '0) |->
      (result_o.rx == '0 && result_o.ry == '0 && result_o.rz == '0))
    else $error("scalar and vector result both set");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status == ST_OK || result_o.status == ST_ZERO ||
                result_o.status == ST_SAT))
    else $error("undefined status code");

endmodule

`default_nettype wire

FILE: test/vector3_alu_test.sv
// Testbench for vector3_alu: drives command items, predicts each result with a
// wide-integer model of the Q16.16 vector operations and checks every strobe.
// Depends on v3alu_pkg and vector3_alu.
`timescale 1ns / 1ps

module vector3_alu_test;
  import v3alu_pkg::*;

  typedef logic signed [199:0] wide_t;
  typedef struct {
    vec_in_t item;
    bit      drain;
  } job_t;

  localparam int LATENCY = 75;
  localparam int STALL_LIMIT = 4000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  vec_in_t  item_i = '0;
  logic     done_o;
  vec_out_t result_o;

  job_t     jobs[$];
  vec_out_t want_q[$];
  int       fails = 0;
  int       sent = 0;
  int       stall = 0;
  bit       stim_done = 1'b0;

  vector3_alu uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic wide_t floor_div(wide_t a, wide_t n);
    if (a >= 0) return a / n;
    return -((-a + n - 1) / n);
  endfunction

  function automatic wide_t int_sqrt(wide_t s);
    wide_t r, t;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (wide_t'(1) << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp(wide_t v, inout bit sat);
    if (v > wide_t'(32'sh7fffffff)) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -wide_t'(64'sh80000000)) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic vec_out_t vector_result(vec_in_t it);
    vec_out_t r;
    wide_t a[3], b[3], v[3], s, d, n;
    bit sat, vec;
    r = '0;
    sat = 1'b0;
    vec = 1'b1;
    a[0] = $signed(it.ax); a[1] = $signed(it.ay); a[2] = $signed(it.az);
    b[0] = $signed(it.bx); b[1] = $signed(it.by); b[2] = $signed(it.bz);
    s = $signed(it.scale_factor);
    case (it.opcode)
      OP_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
      OP_SCALE: for (int i = 0; i < 3; i++) v[i] = (a[i] * s) >>> FRAC_BITS;
      OP_DOT: begin
        vec = 1'b0;
        d = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC_BITS;
      end
      OP_CROSS: begin
        v[0] = (a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS;
        v[1] = (a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS;
        v[2] = (a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS;
      end
      OP_LENSQ: begin
        vec = 1'b0;
        d = (a[0] * a[0] + a[1] * a[1] + a[2] * a[2]) >>> FRAC_BITS;
      end
      OP_LEN: begin
        vec = 1'b0;
        d = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      end
      OP_DIST: begin
        vec = 1'b0;
        for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
        d = int_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
      end
      OP_UNIT: begin
        n = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (n == 0) begin
          r.status = ST_ZERO;
          return r;
        end
        for (int i = 0; i < 3; i++) v[i] = floor_div(a[i] <<< FRAC_BITS, n);
      end
      OP_PROJECT: begin
        n = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        if (n == 0) begin
          r.status = ST_ZERO;
          return r;
        end
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        for (int i = 0; i < 3; i++) v[i] = floor_div(b[i] * d, n);
      end
      default: return r;
    endcase
    if (vec) begin
      r.rx = clamp(v[0], sat);
      r.ry = clamp(v[1], sat);
      r.rz = clamp(v[2], sat);
    end else begin
      r.rscalar = clamp(d, sat);
    end
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? 32'h80000000 :
                $urandom_range(0, 1) ? 32'h7fffffff : 32'h0;
      2: return 32'($signed($urandom) >>> 8);
      default: return 32'($signed($urandom) >>> $urandom_range(10, 20));
    endcase
  endfunction

  task automatic add_job(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] s,
                         bit drain = 1'b0);
    job_t j;
    j.item = '{op, a, a, a, b, b, b, s};
    j.drain = drain;
    jobs.push_back(j);
  endtask

  task automatic add_random(bit drain);
    job_t j;
    j.item.opcode = $urandom_range(0, 9) == 0 ? 4'($urandom_range(10, 15)) :
                    4'($urandom_range(0, 9));
    j.item.ax = pick_word(); j.item.ay = pick_word(); j.item.az = pick_word();
    j.item.bx = pick_word(); j.item.by = pick_word(); j.item.bz = pick_word();
    j.item.scale_factor = pick_word();
    if ($urandom_range(0, 15) == 0) begin
      j.item.ax = '0; j.item.ay = '0; j.item.az = '0;
    end
    if ($urandom_range(0, 15) == 0) begin
      j.item.bx = '0; j.item.by = '0; j.item.bz = '0;
    end
    j.drain = drain;
    jobs.push_back(j);
  endtask

  initial begin
    for (int op = 0; op < 10; op++) begin
      add_job(4'(op), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      add_job(4'(op), 32'h80000000, 32'h7fffffff, 32'h80000000);
    end
    add_job(OP_UNIT, 32'h0, 32'h00010000, 32'h0);
    add_job(OP_PROJECT, 32'h00020000, 32'h0, 32'h0);
    add_job(4'd10, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_job(4'd15, 32'h12345678, 32'h0, 32'h0);
    for (int i = 0; i < 800; i++) add_random(i == 400);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    job_t j;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        want_q.push_back(vector_result(item_i));
        sent++;
      end
      if (!(start && busy)) begin
        if (jobs.size() == 0) begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end else if (jobs[0].drain && (want_q.size() != 0 || (start && !busy))) begin
          start <= 1'b0;
        end else if (!(sent > 200 && sent < 360) && $urandom_range(0, 99) < 28) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          j = jobs.pop_front();
          item_i <= j.item;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    vec_out_t want;
    if (rst_ni && done_o) begin
      if (want_q.size() == 0) begin
        $error("unexpected result rx=%h ry=%h rz=%h rscalar=%h status=%0d",
               result_o.rx, result_o.ry, result_o.rz, result_o.rscalar, result_o.status);
        fails++;
      end else begin
        want = want_q.pop_front();
        if (result_o.rx !== want.rx) begin
          $error("rx: expected %h, got %h", want.rx, result_o.rx);
          fails++;
        end
        if (result_o.ry !== want.ry) begin
          $error("ry: expected %h, got %h", want.ry, result_o.ry);
          fails++;
        end
        if (result_o.rz !== want.rz) begin
          $error("rz: expected %h, got %h", want.rz, result_o.rz);
          fails++;
        end
        if (result_o.rscalar !== want.rscalar) begin
          $error("rscalar: expected %h, got %h", want.rscalar, result_o.rscalar);
          fails++;
        end
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_o.status);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall <= 0;
    end else begin
      stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (!stim_done) @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 25) @(posedge clk_i);
    if (fails == 0 && want_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
